[sv/tcw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Screen geometry, opcodes, character codes and the control/status bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry
    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = ROWS * COLS;

    // Cell index that can also hold CELLS (the saturated cursor)
    localparam int CELL_W    = $clog2(CELLS + 1);
    // Memory address width
    localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    // Cursor row may reach ROWS, cursor column stays below COLS
    localparam int ROW_CNT_W = $clog2(ROWS + 1);
    localparam int COL_CNT_W = (COLS > 1) ? $clog2(COLS) : 1;

    // Payload field widths
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_DW = CHAR_W + ATTR_W;

    // Opcodes
    localparam logic [OP_W-1:0] OP_PUT_CUR = 2'd0;
    localparam logic [OP_W-1:0] OP_PUT_POS = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
    localparam logic [OP_W-1:0] OP_READ    = 2'd3;

    // Character and attribute codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_DEFAULT = 8'h0f;

    // Controller commands to the datapath
    typedef struct packed {
        logic exec;        // item transfer: update cursor, write or read a cell
        logic clear_step;  // blank one cell of the sweep
        logic load;        // fill the output register
    } tcw_cmd_t;

    // Datapath status to the controller
    typedef struct packed {
        logic is_clear;    // offered item is a clear
        logic clear_done;  // sweep is at the last cell
        logic out_free;    // output register can take a result
    } tcw_stat_t;

endpackage
`default_nettype wire

[sv/tcw_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencing controller
// Accepts an item, runs the clear sweep when asked, then loads the result.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire tcw_pkg::tcw_stat_t stat,
    output tcw_pkg::tcw_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CLEAR = 3'b010,
        S_LOAD  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.exec = s_valid;
                if (s_valid) begin
                    state_next = stat.is_clear ? S_CLEAR : S_LOAD;
                end
            end
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.load = stat.out_free;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

[sv/tcw_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath: cursor, screen memory and output register
// Holds the cursor as row and column, computes the cell touched by an item,
// runs the clear sweep and holds the result until it is taken.
// ----------------------------------------------------------------------------
module tcw_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire tcw_pkg::tcw_cmd_t                 cmd,
    output tcw_pkg::tcw_stat_t                     stat,
    input  wire logic [tcw_pkg::OP_W-1:0]          s_opcode,
    input  wire logic [tcw_pkg::CHAR_W-1:0]        s_char_code,
    input  wire logic [tcw_pkg::COL_W-1:0]         s_column,
    input  wire logic [tcw_pkg::ROW_W-1:0]         s_row_index,
    input  wire logic [tcw_pkg::ATTR_W-1:0]        s_attribute,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [tcw_pkg::CELL_W-1:0]             m_cursor_cell,
    output logic [tcw_pkg::CHAR_W-1:0]             m_read_char,
    output logic [tcw_pkg::ATTR_W-1:0]             m_read_attribute,
    output logic                                   m_out_of_range
);

    logic [tcw_pkg::ROW_CNT_W-1:0] cur_row_reg, cur_row_next;
    logic [tcw_pkg::COL_CNT_W-1:0] cur_col_reg, cur_col_next;
    logic                          flag_reg, flag_next;
    logic                          rd_en_reg, rd_en_next;
    logic [tcw_pkg::ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                          m_valid_reg, m_valid_next;
    logic [tcw_pkg::CELL_W-1:0]    m_cursor_reg;
    logic [tcw_pkg::CHAR_W-1:0]    m_char_reg;
    logic [tcw_pkg::ATTR_W-1:0]    m_attr_reg;
    logic                          m_flag_reg;
    logic [tcw_pkg::CELL_DW-1:0]   rdata_reg;

    logic [tcw_pkg::CELL_DW-1:0]   mem [tcw_pkg::CELLS];

    logic [tcw_pkg::ROW_CNT_W-1:0] in_row, pos_row, row_c, a_row;
    logic [tcw_pkg::COL_CNT_W-1:0] in_col, pos_col, col_c, a_col;
    logic                          on_screen, flag_c, we_c, re_c;
    logic [tcw_pkg::CHAR_W-1:0]    wchar;
    logic [tcw_pkg::ATTR_W-1:0]    attr_eff;
    logic [tcw_pkg::CELL_W-1:0]    cell_addr, cursor_lin;
    logic                          mem_we;
    logic [tcw_pkg::ADDR_W-1:0]    mem_waddr;
    logic [tcw_pkg::CELL_DW-1:0]   mem_wdata;

    // Work out the cursor move and the cell access of the offered item
    always_comb begin
        attr_eff  = (s_attribute == '0) ? tcw_pkg::ATTR_DEFAULT : s_attribute;
        in_row    = tcw_pkg::ROW_CNT_W'(s_row_index);
        in_col    = tcw_pkg::COL_CNT_W'(s_column);
        on_screen = (32'(s_column) < tcw_pkg::COLS) && (32'(s_row_index) < tcw_pkg::ROWS);
        pos_row   = (s_opcode == tcw_pkg::OP_PUT_POS) ? in_row : cur_row_reg;
        pos_col   = (s_opcode == tcw_pkg::OP_PUT_POS) ? in_col : cur_col_reg;
        row_c     = cur_row_reg;
        col_c     = cur_col_reg;
        a_row     = pos_row;
        a_col     = pos_col;
        flag_c    = 1'b0;
        we_c      = 1'b0;
        re_c      = 1'b0;
        wchar     = s_char_code;
        case (s_opcode)
            tcw_pkg::OP_CLEAR: begin
                row_c = '0;
                col_c = '0;
            end
            tcw_pkg::OP_READ: begin
                a_row = in_row;
                a_col = in_col;
                re_c  = on_screen;
            end
            default: begin
                if ((s_opcode == tcw_pkg::OP_PUT_POS) && !on_screen) begin
                    flag_c = 1'b1;
                    row_c  = tcw_pkg::ROW_CNT_W'(tcw_pkg::ROWS);
                    col_c  = '0;
                end else if (s_char_code == tcw_pkg::CH_NEWLINE) begin
                    col_c = '0;
                    if (32'(pos_row) >= tcw_pkg::ROWS - 1) begin
                        row_c = tcw_pkg::ROW_CNT_W'(tcw_pkg::ROWS);
                    end else begin
                        row_c = pos_row + tcw_pkg::ROW_CNT_W'(1);
                    end
                end else if (s_char_code == tcw_pkg::CH_BACKSPACE) begin
                    // Cell 0 leaves everything unchanged
                    if ((pos_row != '0) || (pos_col != '0)) begin
                        we_c  = 1'b1;
                        wchar = tcw_pkg::CH_BLANK;
                        if (pos_col == '0) begin
                            a_row = pos_row - tcw_pkg::ROW_CNT_W'(1);
                            a_col = tcw_pkg::COL_CNT_W'(tcw_pkg::COLS - 1);
                        end else begin
                            a_col = pos_col - tcw_pkg::COL_CNT_W'(1);
                        end
                        row_c = a_row;
                        col_c = a_col;
                    end
                end else if (32'(pos_row) == tcw_pkg::ROWS) begin
                    flag_c = 1'b1;
                    row_c  = tcw_pkg::ROW_CNT_W'(tcw_pkg::ROWS);
                    col_c  = '0;
                end else begin
                    we_c = 1'b1;
                    if (32'(pos_col) == tcw_pkg::COLS - 1) begin
                        row_c = pos_row + tcw_pkg::ROW_CNT_W'(1);
                        col_c = '0;
                    end else begin
                        row_c = pos_row;
                        col_c = pos_col + tcw_pkg::COL_CNT_W'(1);
                    end
                end
            end
        endcase
    end

    assign cell_addr  = tcw_pkg::CELL_W'(a_row) * tcw_pkg::CELL_W'(tcw_pkg::COLS)
                      + tcw_pkg::CELL_W'(a_col);
    assign cursor_lin = tcw_pkg::CELL_W'(cur_row_reg) * tcw_pkg::CELL_W'(tcw_pkg::COLS)
                      + tcw_pkg::CELL_W'(cur_col_reg);

    assign mem_we    = (cmd.exec && we_c) || cmd.clear_step;
    assign mem_waddr = cmd.clear_step ? clr_cnt_reg : cell_addr[tcw_pkg::ADDR_W-1:0];
    assign mem_wdata = cmd.clear_step ? {tcw_pkg::ATTR_DEFAULT, tcw_pkg::CH_BLANK}
                                      : {attr_eff, wchar};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.exec && re_c) begin
            rdata_reg <= mem[cell_addr[tcw_pkg::ADDR_W-1:0]];
        end
    end

    always_comb begin
        cur_row_next = cmd.exec ? row_c  : cur_row_reg;
        cur_col_next = cmd.exec ? col_c  : cur_col_reg;
        flag_next    = cmd.exec ? flag_c : flag_reg;
        rd_en_next   = cmd.exec ? re_c   : rd_en_reg;
        if (cmd.exec) begin
            clr_cnt_next = '0;
        end else if (cmd.clear_step) begin
            clr_cnt_next = clr_cnt_reg + tcw_pkg::ADDR_W'(1);
        end else begin
            clr_cnt_next = clr_cnt_reg;
        end
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            flag_reg    <= 1'b0;
            rd_en_reg   <= 1'b0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            flag_reg    <= flag_next;
            rd_en_reg   <= rd_en_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_cursor_reg <= cursor_lin;
            m_char_reg   <= rd_en_reg ? rdata_reg[tcw_pkg::CHAR_W-1:0] : '0;
            m_attr_reg   <= rd_en_reg ? rdata_reg[tcw_pkg::CELL_DW-1:tcw_pkg::CHAR_W] : '0;
            m_flag_reg   <= flag_reg;
        end
    end

    assign stat.is_clear   = (s_opcode == tcw_pkg::OP_CLEAR);
    assign stat.clear_done = (clr_cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1));
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_cursor_cell    = m_cursor_reg;
    assign m_read_char      = m_char_reg;
    assign m_read_attribute = m_attr_reg;
    assign m_out_of_range   = m_flag_reg;

`ifndef ASSERT_OFF
    // A saturated cursor always sits at column 0 of the row past the screen
    a_cursor_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(cur_row_reg) == tcw_pkg::ROWS) |-> (cur_col_reg == '0))
        else $error("cursor past last row with nonzero column");

    a_cursor_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cur_row_reg) <= tcw_pkg::ROWS)
        else $error("cursor row beyond screen end");

    // A dropped write always leaves the cursor saturated
    a_flag_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        flag_reg |-> (32'(cur_row_reg) == tcw_pkg::ROWS))
        else $error("out_of_range without saturated cursor");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> m_valid_reg)
        else $error("result load did not raise m_valid");
`endif

endmodule
`default_nettype wire

[sv/text_console_writer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// Keeps an 80x25 store of character/attribute cells and a cursor, and runs
// one opcode per item: put at cursor, put at position, clear, read cell.
// ----------------------------------------------------------------------------
// Usage: every item gives exactly one result. For a put, a read or a
// backspace the transfer updates the cursor and accesses the cell memory,
// then the output register is loaded as soon as it is free; a new item is
// taken only once the previous result has been loaded, so items do not
// overlap. A clear sweeps the cell memory one cell per cycle through its
// single write port before its result is loaded. The cursor is reported as
// a linear cell index, saturating at ROWS*COLS. Cells hold no defined value
// after reset; read only cells that were written or cleared since.
// ----------------------------------------------------------------------------
module text_console_writer (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // Item channel
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [tcw_pkg::OP_W-1:0]    s_opcode,
    input  wire logic [tcw_pkg::CHAR_W-1:0]  s_char_code,
    input  wire logic [tcw_pkg::COL_W-1:0]   s_column,
    input  wire logic [tcw_pkg::ROW_W-1:0]   s_row_index,
    input  wire logic [tcw_pkg::ATTR_W-1:0]  s_attribute,
    // Result channel
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [tcw_pkg::CELL_W-1:0]       m_cursor_cell,
    output logic [tcw_pkg::CHAR_W-1:0]       m_read_char,
    output logic [tcw_pkg::ATTR_W-1:0]       m_read_attribute,
    output logic                             m_out_of_range
);

    // Command and status bundles between controller and datapath
    tcw_pkg::tcw_cmd_t  cmd;
    tcw_pkg::tcw_stat_t stat;

    // Controller: take a transfer, sweep on clear, load the result when the
    // output register is free (a waiting result is held there, so the
    // controller can go on working)
    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: cursor registers, cell memory, clear counter, output register
    tcw_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_opcode         (s_opcode),
        .s_char_code      (s_char_code),
        .s_column         (s_column),
        .s_row_index      (s_row_index),
        .s_attribute      (s_attribute),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cursor_cell    (m_cursor_cell),
        .m_read_char      (m_read_char),
        .m_read_attribute (m_read_attribute),
        .m_out_of_range   (m_out_of_range)
    );

endmodule
`default_nettype wire

[verif/console_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// console_checker: result checker of the text console writer
// Watches both channels, runs its own copy of the screen store and cursor on
// every input transfer, and compares each result transfer with the oldest
// outcome still waiting.
// ----------------------------------------------------------------------------
module console_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    input  wire logic                        s_ready,
    input  wire logic [tcw_pkg::OP_W-1:0]    s_opcode,
    input  wire logic [tcw_pkg::CHAR_W-1:0]  s_char_code,
    input  wire logic [tcw_pkg::COL_W-1:0]   s_column,
    input  wire logic [tcw_pkg::ROW_W-1:0]   s_row_index,
    input  wire logic [tcw_pkg::ATTR_W-1:0]  s_attribute,
    input  wire logic                        m_valid,
    input  wire logic                        m_ready,
    input  wire logic [tcw_pkg::CELL_W-1:0]  m_cursor_cell,
    input  wire logic [tcw_pkg::CHAR_W-1:0]  m_read_char,
    input  wire logic [tcw_pkg::ATTR_W-1:0]  m_read_attribute,
    input  wire logic                        m_out_of_range,
    output int                               mismatch_count,
    output int                               outstanding
);

    typedef struct packed {
        logic [tcw_pkg::CELL_W-1:0] cursor;
        logic [tcw_pkg::CHAR_W-1:0] rd_char;
        logic [tcw_pkg::ATTR_W-1:0] rd_attr;
        logic                       oor;
    } console_outcome_t;

    logic [tcw_pkg::CELL_DW-1:0] screen_mem [tcw_pkg::CELLS];
    int                          cursor_idx;
    console_outcome_t            console_outcomes [$];

    initial begin
        mismatch_count = 0;
        outstanding    = 0;
        cursor_idx     = 0;
    end

    // Apply one item to the screen copy and return the result it gives
    function automatic console_outcome_t run_console_op(
        input logic [tcw_pkg::OP_W-1:0]   op,
        input logic [tcw_pkg::CHAR_W-1:0] ch,
        input logic [tcw_pkg::COL_W-1:0]  col,
        input logic [tcw_pkg::ROW_W-1:0]  row,
        input logic [tcw_pkg::ATTR_W-1:0] attr
    );
        console_outcome_t          res;
        logic [tcw_pkg::ATTR_W-1:0] eff_attr;
        logic                       on_screen;
        int                         pos;
        int                         next_line;
        int                         i;
        res       = '0;
        eff_attr  = (attr == '0) ? tcw_pkg::ATTR_DEFAULT : attr;
        on_screen = (int'(col) < tcw_pkg::COLS) && (int'(row) < tcw_pkg::ROWS);
        if (op == tcw_pkg::OP_CLEAR) begin
            for (i = 0; i < tcw_pkg::CELLS; i++)
                screen_mem[i] = {tcw_pkg::ATTR_DEFAULT, tcw_pkg::CH_BLANK};
            cursor_idx = 0;
        end else if (op == tcw_pkg::OP_READ) begin
            if (on_screen) begin
                pos         = int'(row) * tcw_pkg::COLS + int'(col);
                res.rd_char = screen_mem[pos][tcw_pkg::CHAR_W-1:0];
                res.rd_attr = screen_mem[pos][tcw_pkg::CELL_DW-1:tcw_pkg::CHAR_W];
            end
        end else if (op == tcw_pkg::OP_PUT_POS && !on_screen) begin
            res.oor    = 1'b1;
            cursor_idx = tcw_pkg::CELLS;
        end else begin
            pos = (op == tcw_pkg::OP_PUT_POS) ? int'(row) * tcw_pkg::COLS + int'(col)
                                              : cursor_idx;
            if (pos > tcw_pkg::CELLS)
                pos = tcw_pkg::CELLS;
            if (ch == tcw_pkg::CH_NEWLINE) begin
                next_line  = (pos / tcw_pkg::COLS + 1) * tcw_pkg::COLS;
                cursor_idx = (next_line > tcw_pkg::CELLS) ? tcw_pkg::CELLS : next_line;
            end else if (ch == tcw_pkg::CH_BACKSPACE) begin
                // backspace at cell 0 leaves everything alone
                if (pos >= 1) begin
                    pos             = pos - 1;
                    screen_mem[pos] = {eff_attr, tcw_pkg::CH_BLANK};
                    cursor_idx      = pos;
                end
            end else if (pos < tcw_pkg::CELLS) begin
                screen_mem[pos] = {eff_attr, ch};
                cursor_idx      = pos + 1;
            end else begin
                res.oor    = 1'b1;
                cursor_idx = tcw_pkg::CELLS;
            end
        end
        res.cursor = cursor_idx[tcw_pkg::CELL_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        console_outcome_t got;
        console_outcome_t want;
        int               errs;
        errs = 0;
        if (!aresetn) begin
            cursor_idx = 0;
            console_outcomes.delete();
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got.cursor  = m_cursor_cell;
                got.rd_char = m_read_char;
                got.rd_attr = m_read_attribute;
                got.oor     = m_out_of_range;
                if (console_outcomes.size() == 0) begin
                    $display("%0t: result transfer with no outcome waiting, cursor_cell %0d",
                             $time, got.cursor);
                    errs++;
                end else begin
                    want = console_outcomes.pop_front();
                    if (got.cursor !== want.cursor) begin
                        $display("%0t: cursor_cell expected %0d actual %0d",
                                 $time, want.cursor, got.cursor);
                        errs++;
                    end
                    if (got.rd_char !== want.rd_char) begin
                        $display("%0t: read_char expected 0x%02h actual 0x%02h",
                                 $time, want.rd_char, got.rd_char);
                        errs++;
                    end
                    if (got.rd_attr !== want.rd_attr) begin
                        $display("%0t: read_attribute expected 0x%02h actual 0x%02h",
                                 $time, want.rd_attr, got.rd_attr);
                        errs++;
                    end
                    if (got.oor !== want.oor) begin
                        $display("%0t: out_of_range expected %0d actual %0d",
                                 $time, want.oor, got.oor);
                        errs++;
                    end
                end
            end
            if (s_valid && s_ready)
                console_outcomes.push_back(run_console_op(s_opcode, s_char_code, s_column,
                                                          s_row_index, s_attribute));
            outstanding <= console_outcomes.size();
        end
        if (errs != 0)
            mismatch_count <= mismatch_count + errs;
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the text console writer
// Drives directed items over the screen edges and special characters, then
// a long random mix of puts, reads and clears with random gaps on both
// channels. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [tcw_pkg::OP_W-1:0]    s_opcode;
    logic [tcw_pkg::CHAR_W-1:0]  s_char_code;
    logic [tcw_pkg::COL_W-1:0]   s_column;
    logic [tcw_pkg::ROW_W-1:0]   s_row_index;
    logic [tcw_pkg::ATTR_W-1:0]  s_attribute;
    logic                        m_valid;
    logic                        m_ready;
    logic [tcw_pkg::CELL_W-1:0]  m_cursor_cell;
    logic [tcw_pkg::CHAR_W-1:0]  m_read_char;
    logic [tcw_pkg::ATTR_W-1:0]  m_read_attribute;
    logic                        m_out_of_range;

    int mismatch_count;
    int outstanding;

    // Longest wait each side may draw before a transfer; changed per segment
    int  sender_gap_max   = 3;
    int  receiver_gap_max = 3;
    // Set by the stimulus to make the receiver hold off for a long stretch
    bit  hold_off_req     = 1'b0;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 1830;

    text_console_writer i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_char_code      (s_char_code),
        .s_column         (s_column),
        .s_row_index      (s_row_index),
        .s_attribute      (s_attribute),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cursor_cell    (m_cursor_cell),
        .m_read_char      (m_read_char),
        .m_read_attribute (m_read_attribute),
        .m_out_of_range   (m_out_of_range)
    );

    console_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_char_code      (s_char_code),
        .s_column         (s_column),
        .s_row_index      (s_row_index),
        .s_attribute      (s_attribute),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cursor_cell    (m_cursor_cell),
        .m_read_char      (m_read_char),
        .m_read_attribute (m_read_attribute),
        .m_out_of_range   (m_out_of_range),
        .mismatch_count   (mismatch_count),
        .outstanding      (outstanding)
    );

    // 10 ns clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Generous fixed limit: a correct run needs well under a tenth of this
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one item after a random gap and hold it until the transfer.
    // Valid is lowered only when a gap follows, never in the step it rises.
    task automatic send_item(
        input logic [tcw_pkg::OP_W-1:0]   op,
        input logic [tcw_pkg::CHAR_W-1:0] ch,
        input logic [tcw_pkg::COL_W-1:0]  col,
        input logic [tcw_pkg::ROW_W-1:0]  row,
        input logic [tcw_pkg::ATTR_W-1:0] attr
    );
        int gap;
        gap = $urandom_range(0, sender_gap_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_opcode    <= op;
        s_char_code <= ch;
        s_column    <= col;
        s_row_index <= row;
        s_attribute <= attr;
        s_valid     <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid and wait until every outcome has come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    // Receiver: draw a stall per result, or the long hold-off on request
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(negedge aclk);
            stall = $urandom_range(0, receiver_gap_max);
            if (hold_off_req) begin
                stall        = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    // Stimulus
    initial begin
        logic [tcw_pkg::OP_W-1:0]   op;
        logic [tcw_pkg::CHAR_W-1:0] ch;
        logic [tcw_pkg::COL_W-1:0]  col;
        logic [tcw_pkg::ROW_W-1:0]  row;
        logic [tcw_pkg::ATTR_W-1:0] attr;
        int                         pick;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_opcode    = tcw_pkg::OP_PUT_CUR;
        s_char_code = '0;
        s_column    = '0;
        s_row_index = '0;
        s_attribute = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Before the first clear, read only cells just written by position
        send_item(tcw_pkg::OP_PUT_POS, 8'h41, 7'd0, 5'd0, 8'h00);
        send_item(tcw_pkg::OP_READ, 8'hff, 7'd0, 5'd0, 8'hff);
        send_item(tcw_pkg::OP_PUT_POS, 8'hff, 7'd79, 5'd24, 8'hff);
        send_item(tcw_pkg::OP_READ, 8'h00, 7'd79, 5'd24, 8'h00);
        // reads off the screen return zeros and no flag
        send_item(tcw_pkg::OP_READ, 8'h55, 7'd127, 5'd31, 8'haa);
        send_item(tcw_pkg::OP_READ, 8'h00, 7'd0, 5'd25, 8'h00);
        // clear ignores the other fields
        send_item(tcw_pkg::OP_CLEAR, 8'h41, 7'd127, 5'd31, 8'h77);
        send_item(tcw_pkg::OP_READ, 8'h00, 7'd0, 5'd0, 8'h00);
        // backspace with the cursor at cell 0 does nothing
        send_item(tcw_pkg::OP_PUT_CUR, tcw_pkg::CH_BACKSPACE, 7'd0, 5'd0, 8'h12);
        send_item(tcw_pkg::OP_PUT_CUR, 8'h00, 7'd0, 5'd0, 8'h01);
        send_item(tcw_pkg::OP_PUT_CUR, tcw_pkg::CH_NEWLINE, 7'd0, 5'd0, 8'h01);
        // backspace blanks the previous cell with the default attribute
        send_item(tcw_pkg::OP_PUT_CUR, tcw_pkg::CH_BACKSPACE, 7'd0, 5'd0, 8'h00);
        send_item(tcw_pkg::OP_READ, 8'h00, 7'd79, 5'd0, 8'h00);
        // newline on the last row saturates the cursor, no flag
        send_item(tcw_pkg::OP_PUT_POS, tcw_pkg::CH_NEWLINE, 7'd79, 5'd24, 8'h30);
        // cursor at the end: printable dropped and flagged
        send_item(tcw_pkg::OP_PUT_CUR, 8'h78, 7'd0, 5'd0, 8'h30);
        send_item(tcw_pkg::OP_PUT_CUR, tcw_pkg::CH_NEWLINE, 7'd0, 5'd0, 8'h30);
        send_item(tcw_pkg::OP_PUT_CUR, tcw_pkg::CH_BACKSPACE, 7'd0, 5'd0, 8'h44);
        // positions off the screen flag and saturate for any character
        send_item(tcw_pkg::OP_PUT_POS, 8'h7a, 7'd80, 5'd0, 8'h01);
        send_item(tcw_pkg::OP_PUT_POS, tcw_pkg::CH_NEWLINE, 7'd0, 5'd25, 8'h01);
        send_item(tcw_pkg::OP_PUT_POS, tcw_pkg::CH_BACKSPACE, 7'd127, 5'd31, 8'h01);
        send_item(tcw_pkg::OP_PUT_POS, tcw_pkg::CH_BACKSPACE, 7'd40, 5'd10, 8'h80);
        send_item(tcw_pkg::OP_READ, 8'h00, 7'd39, 5'd10, 8'h00);
        send_item(tcw_pkg::OP_PUT_POS, tcw_pkg::CH_BACKSPACE, 7'd0, 5'd0, 8'h80);
        send_item(tcw_pkg::OP_READ, 8'h00, 7'd79, 5'd24, 8'h00);

        // Random mix; every cell is defined now, so any read is legal
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // pick new idling for both sides every segment
            if (n % 128 == 0) begin
                case ($urandom_range(0, 2))
                    0: sender_gap_max = 0;
                    1: sender_gap_max = 2;
                    default: sender_gap_max = 12;
                endcase
                case ($urandom_range(0, 2))
                    0: receiver_gap_max = 0;
                    1: receiver_gap_max = 2;
                    default: receiver_gap_max = 12;
                endcase
            end
            // receiver holds off while items keep coming, so the input stalls
            if (n == 300)
                hold_off_req = 1'b1;
            // sender pauses until every result is back
            if (n == 700 || n == 1400)
                drain_results();

            pick = $urandom_range(0, 99);
            if (pick < 1)
                op = tcw_pkg::OP_CLEAR;
            else if (pick < 46)
                op = tcw_pkg::OP_PUT_CUR;
            else if (pick < 70)
                op = tcw_pkg::OP_PUT_POS;
            else
                op = tcw_pkg::OP_READ;

            case ($urandom_range(0, 9))
                0, 1: ch = tcw_pkg::CH_NEWLINE;
                2: ch = tcw_pkg::CH_BACKSPACE;
                default: ch = 8'($urandom_range(0, 255));
            endcase

            // mostly on the screen, sometimes anywhere the fields reach
            if ($urandom_range(0, 99) < 85) begin
                col = 7'($urandom_range(0, tcw_pkg::COLS - 1));
                row = 5'($urandom_range(0, tcw_pkg::ROWS - 1));
            end else begin
                col = 7'($urandom_range(0, 127));
                row = 5'($urandom_range(0, 31));
            end

            attr = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            send_item(op, ch, col, row, attr);
        end

        // Drain, then allow for the block's latency before the verdict
        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
